// ----- src/fir21_pkg.sv -----
// ----------------------------------------------------------------------------
// fir21_pkg: shared types and constants for the 21-tap three-band FIR
// Holds the tap count, the coefficient tables in Q30, the rounding function
// that brings a Q30 coefficient to the working fraction, and the pipeline
// control word passed between stages.
// ----------------------------------------------------------------------------
package fir21_pkg;

    localparam int TAPS      = 21;
    localparam int HALF_TAPS = (TAPS + 1) / 2;
    localparam int NUM_SETS  = 3;
    localparam int SAMPLE_W  = 16;
    localparam int SEL_W     = 2;
    localparam int Q30_FRAC  = 30;

    // Saturation bounds of a 16-bit sample
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Coefficient set indexes into the table
    localparam int SET_LOW  = 0;
    localparam int SET_HIGH = 1;
    localparam int SET_BAND = 2;

    // Selector codes of the filter_select register
    localparam logic [SEL_W-1:0] SEL_LOW  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_HIGH = 2'd1;

    // First half (taps 0 .. 10) of each symmetric set, Q30
    localparam int COEF_Q30 [NUM_SETS][HALF_TAPS] = '{
        '{0, -331917, -1009479, 2908721, 10873207, 0,
          -41413187, -46134735, 85274147, 312028246, 429351817},
        '{0, 3710050, -4223655, -7753602, 21597800, 0,
          -55546606, 54377533, 91809287, -318382781, 430370570},
        '{0, 0, 2819198, 0, -30365891, 0,
          115655698, 0, -238147359, 0, 299765534}
    };

    // Control word that steps the pipeline
    typedef struct packed {
        logic adv;     // all stages move one place
        logic accept;  // a new input word enters the window
    } pipe_ctl_t;

    // Round the Q30 coefficient of one tap to Q(frac): magnitude rounded to
    // nearest with ties away from zero, then the sign put back
    function automatic longint coef_q(input int set, input int tap, input int frac);
        int     m;
        int     sh;
        longint q30;
        longint mag;
        m   = (tap < HALF_TAPS) ? tap : (TAPS - 1 - tap);
        sh  = Q30_FRAC - frac;
        q30 = longint'(COEF_Q30[set][m]);
        mag = (q30 < 0) ? -q30 : q30;
        if (sh > 0)
        begin
            mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        end
        return (q30 < 0) ? -mag : mag;
    endfunction

endpackage

// ----- src/fir21_taps.sv -----
// ----------------------------------------------------------------------------
// fir21_taps: sample window and tap multipliers
// Shifts each accepted sample into a 21-entry window (newest at entry 0) and
// forms one registered product per tap with the selected coefficient set.
// ----------------------------------------------------------------------------
module fir21_taps
    import fir21_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pipe_ctl_t                             ctl,
    input  logic signed [SAMPLE_W-1:0]            sample,
    input  logic        [SEL_W-1:0]               sel,
    output logic signed [SAMPLE_W+COEF_FRAC_BITS:0] prod [TAPS],
    output logic                                  prod_valid
);

    localparam int CW = COEF_FRAC_BITS + 1;
    localparam int PW = SAMPLE_W + CW;

    logic signed [SAMPLE_W-1:0] window_reg [TAPS];
    logic                       win_valid_reg;
    logic signed [CW-1:0]       coef [TAPS];
    logic signed [PW-1:0]       prod_reg [TAPS];
    logic                       prod_valid_reg;

    // Pick the coefficient of each tap from the three fixed sets
    for (genvar k = 0; k < TAPS; k++)
    begin : g_coef
        localparam logic signed [CW-1:0] C_LOW  = CW'(coef_q(SET_LOW,  k, COEF_FRAC_BITS));
        localparam logic signed [CW-1:0] C_HIGH = CW'(coef_q(SET_HIGH, k, COEF_FRAC_BITS));
        localparam logic signed [CW-1:0] C_BAND = CW'(coef_q(SET_BAND, k, COEF_FRAC_BITS));

        always_comb
        begin
            unique case (sel)
                SEL_LOW:  coef[k] = C_LOW;
                SEL_HIGH: coef[k] = C_HIGH;
                default:  coef[k] = C_BAND;
            endcase
        end
    end

    // Shift the window on accept; advance the valid flag with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                window_reg[k] <= '0;
            end
            win_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            if (ctl.accept)
            begin
                window_reg[0] <= sample;
                for (int k = 1; k < TAPS; k++)
                begin
                    window_reg[k] <= window_reg[k-1];
                end
            end
            win_valid_reg  <= ctl.accept;
            prod_valid_reg <= win_valid_reg;
        end
    end

    // Register one product per tap
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                prod_reg[k] <= PW'(coef[k]) * PW'(window_reg[k]);
            end
        end
    end

    assign prod       = prod_reg;
    assign prod_valid = prod_valid_reg;

endmodule

// ----- src/fir21_sum.sv -----
// ----------------------------------------------------------------------------
// fir21_sum: adder tree, scaling and saturation
// Adds the 21 tap products in a registered tree of three levels, shifts the
// sum right by the coefficient fraction (floor) and clamps to 16 bits.
// ----------------------------------------------------------------------------
module fir21_sum
    import fir21_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pipe_ctl_t                             ctl,
    input  logic signed [SAMPLE_W+COEF_FRAC_BITS:0] prod [TAPS],
    input  logic                                  prod_valid,
    output logic signed [SAMPLE_W-1:0]            filtered,
    output logic                                  out_valid
);

    localparam int PW  = SAMPLE_W + COEF_FRAC_BITS + 1;
    localparam int G1N = TAPS / 3;
    localparam int G2N = (G1N + 2) / 3;
    localparam int G1W = PW + 2;
    localparam int G2W = PW + 4;
    localparam int AW  = PW + 5;

    localparam logic signed [AW-1:0] SAT_MAX = AW'(SAMPLE_MAX);
    localparam logic signed [AW-1:0] SAT_MIN = AW'(SAMPLE_MIN);

    logic signed [G1W-1:0]      grp1_reg [G1N];
    logic signed [G2W-1:0]      grp2_reg [G2N];
    logic signed [AW-1:0]       acc_reg;
    logic signed [AW-1:0]       scaled;
    logic signed [SAMPLE_W-1:0] sat_next;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       g1_valid_reg;
    logic                       g2_valid_reg;
    logic                       acc_valid_reg;
    logic                       out_valid_reg;

    // Floor shift, then clamp to the 16-bit range
    always_comb
    begin
        scaled = acc_reg >>> COEF_FRAC_BITS;
        priority if (scaled > SAT_MAX)
        begin
            sat_next = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (scaled < SAT_MIN)
        begin
            sat_next = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            sat_next = scaled[SAMPLE_W-1:0];
        end
    end

    // Advance the tree payload
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int i = 0; i < G1N; i++)
            begin
                grp1_reg[i] <= G1W'(prod[3*i]) + G1W'(prod[3*i+1]) + G1W'(prod[3*i+2]);
            end
            grp2_reg[0] <= G2W'(grp1_reg[0]) + G2W'(grp1_reg[1]) + G2W'(grp1_reg[2]);
            grp2_reg[1] <= G2W'(grp1_reg[3]) + G2W'(grp1_reg[4]) + G2W'(grp1_reg[5]);
            grp2_reg[2] <= G2W'(grp1_reg[6]);
            acc_reg     <= AW'(grp2_reg[0]) + AW'(grp2_reg[1]) + AW'(grp2_reg[2]);
            filtered_reg <= sat_next;
        end
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg  <= 1'b0;
            g2_valid_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            g1_valid_reg  <= prod_valid;
            g2_valid_reg  <= g1_valid_reg;
            acc_valid_reg <= g2_valid_reg;
            out_valid_reg <= acc_valid_reg;
        end
    end

    assign filtered  = filtered_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- src/fir_filter_21tap_three_band.sv -----
// ----------------------------------------------------------------------------
// fir_filter_21tap_three_band: 21-tap FIR with low/high/band-pass selection
// Takes one signed 16-bit word per cycle unless in_stall is high and returns
// one filtered word per accepted word. The pipeline runs window register, one
// multiplier per tap, a three-level registered adder tree, then the floor
// shift and 16-bit saturation into the output register; the whole pipeline
// freezes only while a finished word sits stalled at the output. The
// delay line clears at reset. filter_select (0 low-pass, 1 high-pass,
// 2 or 3 band-pass) is taken on any cfg_valid cycle and must be changed only
// with the pipeline empty.
// ----------------------------------------------------------------------------
module fir_filter_21tap_three_band
    import fir21_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] filtered,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [SEL_W-1:0]    filter_select
);

    localparam int PW = SAMPLE_W + COEF_FRAC_BITS + 1;

    logic [SEL_W-1:0]     sel_reg;
    pipe_ctl_t            ctl;
    logic signed [PW-1:0] prod [TAPS];
    logic                 prod_valid;

    // Move the pipeline unless the output word is held
    assign ctl.adv    = !(out_valid && out_stall);
    assign ctl.accept = in_valid && ctl.adv;
    assign in_stall   = !ctl.adv;
    assign cfg_ready  = 1'b1;

    // Hold the coefficient set selector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= SEL_LOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sel_reg <= filter_select;
        end
    end

    fir21_taps #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_taps (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample     (sample),
        .sel        (sel_reg),
        .prod       (prod),
        .prod_valid (prod_valid)
    );

    fir21_sum #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prod       (prod),
        .prod_valid (prod_valid),
        .filtered   (filtered),
        .out_valid  (out_valid)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 21-tap three-band FIR filter
// Streams signed 16-bit words through the filter under every band setting,
// predicts each filtered word with an exact wide sum of Q15 products, floor
// shift and saturation, and compares results in order. Random idling on both
// sides, a long output hold and a full drain exercise the stall path.
// ----------------------------------------------------------------------------
module tb;
    import fir21_pkg::SAMPLE_W;
    import fir21_pkg::SEL_W;
    import fir21_pkg::SEL_LOW;
    import fir21_pkg::SEL_HIGH;

    localparam int FRAC_BITS   = 15;
    localparam int TAP_COUNT   = 21;
    localparam int HIST_COUNT  = TAP_COUNT - 1;
    localparam int HALF_COUNT  = (TAP_COUNT + 1) / 2;
    localparam int SET_COUNT   = 3;
    localparam int TABLE_FRAC  = 30;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 16;

    // Band codes beyond the two the package names
    localparam logic [SEL_W-1:0] SEL_BAND  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] WORD_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] WORD_MIN = 16'sh8000;

    // Symmetric coefficient halves, Q30, in select order
    localparam int BAND_Q30 [SET_COUNT][HALF_COUNT] = '{
        '{0, -331917, -1009479, 2908721, 10873207, 0,
          -41413187, -46134735, 85274147, 312028246, 429351817},
        '{0, 3710050, -4223655, -7753602, 21597800, 0,
          -55546606, 54377533, 91809287, -318382781, 430370570},
        '{0, 0, 2819198, 0, -30365891, 0,
          115655698, 0, -238147359, 0, 299765534}
    };

    // ------------------------------------------------------------------------
    // Filter output predictor and in-order result store
    // ------------------------------------------------------------------------
    class fir_scoreboard;
        logic signed [SAMPLE_W-1:0] history [HIST_COUNT];
        logic [SEL_W-1:0]           band;
        longint                     coef [SET_COUNT][TAP_COUNT];
        logic signed [SAMPLE_W-1:0] expected_words [$];
        int unsigned                checked;
        int unsigned                mismatches;
        int unsigned                clipped;

        function new(int frac);
            int     s;
            int     k;
            int     m;
            int     sh;
            longint raw;
            longint mag;
            sh = TABLE_FRAC - frac;
            for (s = 0; s < SET_COUNT; s++)
            begin
                for (k = 0; k < TAP_COUNT; k++)
                begin
                    // mirror the half table, round magnitude half away from zero
                    m   = (k < HALF_COUNT) ? k : (TAP_COUNT - 1 - k);
                    raw = longint'(BAND_Q30[s][m]);
                    mag = (raw < 0) ? -raw : raw;
                    if (sh > 0)
                        mag = (mag + (longint'(1) << (sh - 1))) / (longint'(1) << sh);
                    coef[s][k] = (raw < 0) ? -mag : mag;
                end
            end
            foreach (history[i])
                history[i] = '0;
            band       = SEL_LOW;
            checked    = 0;
            mismatches = 0;
            clipped    = 0;
        endfunction

        function int active_set();
            return (band == SEL_LOW || band == SEL_HIGH) ? int'(band) : int'(SEL_BAND);
        endfunction

        function void set_band(logic [SEL_W-1:0] v);
            band = v;
        endfunction

        function bit tap_negative(int k);
            return coef[active_set()][k] < 0;
        endfunction

        // Form the expected word for one accepted sample, then advance history
        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            int     s;
            int     k;
            longint acc;
            longint y;
            s   = active_set();
            acc = coef[s][0] * longint'(x);
            for (k = 1; k < TAP_COUNT; k++)
                acc += coef[s][k] * longint'(history[k-1]);
            y = acc >>> FRAC_BITS;
            if (y > longint'(WORD_MAX))
            begin
                y = longint'(WORD_MAX);
                clipped++;
            end
            else if (y < longint'(WORD_MIN))
            begin
                y = longint'(WORD_MIN);
                clipped++;
            end
            expected_words.push_back(y[SAMPLE_W-1:0]);
            for (k = HIST_COUNT - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = x;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected filtered word, expected none, actual %0d",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                checked++;
                if (got !== want)
                begin
                    $display("%0t: filtered mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    typedef enum int { RUN_ALIGNED, RUN_EXTREME, RUN_UNIFORM, RUN_SMALL } run_kind_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample        = '0;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [SEL_W-1:0]           filter_select = SEL_LOW;

    fir_scoreboard sb;
    bit            quiet      = 1'b0;
    int            hold_asks  = 0;
    int            hold_seen  = 0;
    int            hold_left  = 0;
    int unsigned   cycles     = 0;
    int unsigned   sent       = 0;
    int unsigned   band_moves = 0;

    fir_filter_21tap_three_band #(
        .COEF_FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .filter_select(filter_select)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive output stall: long hold on request, else random idling
    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Check each result word that the next edge will take
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(filtered);
    end

    // Offer one word, hold it until taken, then maybe idle
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        sample   <= s;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        sb.note_sample(s);
        sent++;
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every expected word to come back
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_select(input logic [SEL_W-1:0] v);
        cfg_valid     <= 1'b1;
        filter_select <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_band(v);
        band_moves++;
    endtask

    // Sample whose sign matches tap k (opposes it when flip is set), so a full run drives the sum toward a rail
    function automatic logic signed [SAMPLE_W-1:0] aligned_word(int k, bit flip);
        int mag;
        mag = $urandom_range(24000, 32767);
        return (sb.tap_negative(k) ^ flip) ? SAMPLE_W'(-mag - 1) : SAMPLE_W'(mag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_word(run_kind_t kind);
        logic signed [SAMPLE_W-1:0] w;
        case (kind)
            RUN_EXTREME:
            begin
                case ($urandom_range(3))
                    0:       w = WORD_MAX;
                    1:       w = WORD_MIN;
                    2:       w = WORD_MAX - SAMPLE_W'($urandom_range(255));
                    default: w = WORD_MIN + SAMPLE_W'($urandom_range(255));
                endcase
            end
            RUN_SMALL:
                w = SAMPLE_W'($urandom_range(32)) - SAMPLE_W'(16);
            default:
                w = SAMPLE_W'($urandom_range(65535));
        endcase
        return w;
    endfunction

    // One band setting: rail-seeking runs most often, the rest mixed content
    task automatic run_phase(input logic [SEL_W-1:0] sel, input int count,
                             input bit hold, input bit pause);
        int        n;
        int        j;
        int        len;
        bit        flip;
        bit        held;
        bit        paused;
        run_kind_t kind;
        n      = 0;
        held   = 1'b0;
        paused = 1'b0;
        write_select(sel);
        while (n < count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: kind = RUN_ALIGNED;
                4, 5:       kind = RUN_EXTREME;
                6:          kind = RUN_SMALL;
                default:    kind = RUN_UNIFORM;
            endcase
            if (kind == RUN_ALIGNED)
            begin
                flip = $urandom_range(1);
                for (j = 0; j < TAP_COUNT; j++)
                    push_sample(aligned_word(j, flip));
                n += TAP_COUNT;
            end
            else
            begin
                len = $urandom_range(4, 12);
                for (j = 0; j < len; j++)
                    push_sample(random_word(kind));
                n += len;
            end
            // back up the pipeline against a stalled output
            if (hold && !held && n >= count / 3)
            begin
                hold_asks++;
                held = 1'b1;
            end
            if (pause && !paused && n >= count / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial
    begin
        int j;
        sb = new(FRAC_BITS);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rails, unit steps, then a run that clips high
        write_select(SEL_LOW);
        push_sample(WORD_MIN);
        push_sample(WORD_MAX);
        push_sample('0);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        for (j = 0; j < TAP_COUNT; j++)
            push_sample(sb.tap_negative(j) ? WORD_MIN : WORD_MAX);
        drain();

        run_phase(SEL_HIGH,  140, 1'b0, 1'b0);
        run_phase(SEL_BAND,  140, 1'b1, 1'b0);
        run_phase(SEL_SPARE, 130, 1'b0, 1'b0);
        quiet = 1'b1;
        run_phase(SEL_LOW,   140, 1'b0, 1'b0);
        quiet = 1'b0;
        run_phase(SEL_HIGH,  130, 1'b0, 1'b1);
        run_phase(SEL_BAND,  120, 1'b1, 1'b0);
        run_phase(SEL_LOW,   110, 1'b0, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d samples across %0d band writes (all four select codes).",
                 sent, band_moves);
        $display("Checked %0d filtered words, %0d clipped at a rail, %0d errors.",
                 sb.checked, sb.clipped, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
